### hdl/cpt_pkg.sv
`timescale 1ns / 1ps
// Shared widths, data types and region codes of the closest-point pipeline.
package cpt_pkg;

	// Coordinate and difference widths.
	localparam int CW  = 32;
	localparam int DW  = CW + 1;
	// Dot product terms and sums.
	localparam int PW  = 2 * DW;
	localparam int DTW = PW + 2;
	// Split multiplier for the cross terms of the dot products.
	localparam int HW  = DTW / 2;
	localparam int MDW = 2 * HW + 2;
	localparam int MW  = 2 * DTW;
	localparam int VW  = MW + 1;
	// Parameters of the closest point (numerators, denominators).
	localparam int TW  = VW + 2;
	localparam int CKW = 28;
	localparam int NCK = (TW + CKW) / CKW;
	localparam int TXW = NCK * CKW;
	localparam int PPW = DW + CKW + 1;
	localparam int PRW = DW + TW;
	localparam int NW  = PRW + 1;
	// Divider: quotient bits, remainder width, output sum width.
	localparam int QB  = 36;
	localparam int QW  = QB + 1;
	localparam int RW  = TW + QB + 1;
	localparam int SW  = QW + 2;
	// Latency of the front pipeline, the divider and the whole block.
	localparam int FRONT_LAT = 10;
	localparam int DIV_LAT   = QB + 4;
	localparam int LAT       = FRONT_LAT + DIV_LAT;

	typedef logic signed [CW-1:0]  crd_t;
	typedef logic signed [DW-1:0]  dif_t;
	typedef logic signed [PW-1:0]  pro_t;
	typedef logic signed [DTW-1:0] dot_t;
	typedef logic signed [TW-1:0]  par_t;

	// Region codes of the result.
	typedef enum logic [2:0] {
		RG_A   = 3'd0,
		RG_B   = 3'd1,
		RG_AB  = 3'd2,
		RG_C   = 3'd3,
		RG_AC  = 3'd4,
		RG_BC  = 3'd5,
		RG_INT = 3'd6,
		RG_DEG = 3'd7
	} region_t;

	// Triangle vertices and edge vectors carried down the front pipeline.
	typedef struct packed {
		crd_t [2:0] a;
		crd_t [2:0] b;
		crd_t [2:0] c;
		dif_t [2:0] ab;
		dif_t [2:0] ac;
		dif_t [2:0] bc;
	} geo_t;

	// Edge parameters and region tests that depend on the dot products only.
	typedef struct packed {
		par_t t_ab;
		par_t t_ac;
		par_t t_bc;
		par_t n_ab;
		par_t n_ac;
		par_t n_bc;
		logic f0;
		logic f1;
		logic f2p;
		logic f3;
		logic f4p;
		logic f5p;
	} sel_t;

endpackage

### hdl/cpt_div.sv
`timescale 1ns / 1ps
// Pipelined rounding divider that adds the quotient to a base coordinate and clamps it.
module cpt_div
	import cpt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_vld,
	input  logic signed [NW-1:0] num,
	input  par_t                 den,
	input  crd_t                 base,
	output logic                 out_vld,
	output crd_t                 coord
);

	// Stage 1: magnitudes, quotient sign and zero denominator.
	logic          v_s1;
	logic [NW-1:0] nm_s1;
	logic [TW-1:0] dm_s1;
	logic          neg_s1;
	logic          dz_s1;
	crd_t          base_s1;

	// Restoring steps: index 0 holds the overflow check, each next index one quotient bit.
	logic          v_s   [QB+1];
	logic [RW-1:0] rem_s [QB+1];
	logic [QB-1:0] q_s   [QB+1];
	logic [TW-1:0] dm_s  [QB+1];
	logic          ovf_s [QB+1];
	logic          neg_s [QB+1];
	logic          dz_s  [QB+1];
	crd_t          base_s[QB+1];

	// Rounding stage.
	logic          v_sr;
	logic [QW-1:0] qm_sr;
	logic          neg_sr;
	crd_t          base_sr;

	// Final sum before the clamp.
	logic signed [QW:0]   qs;
	logic signed [SW-1:0] sum;
	logic                 fits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s[0] <= 1'b0;
			v_sr <= 1'b0;
			out_vld <= 1'b0;
		end else begin
			v_s1 <= in_vld;
			v_s[0] <= v_s1;
			v_sr <= v_s[QB];
			out_vld <= v_sr;
		end
	end

	// Take magnitudes so the steps work on unsigned values.
	always_ff @(posedge clk) begin
		nm_s1 <= num[NW-1] ? NW'(-num) : NW'(num);
		dm_s1 <= den[TW-1] ? TW'(-den) : TW'(den);
		neg_s1 <= num[NW-1] ^ den[TW-1];
		dz_s1 <= (den == '0);
		base_s1 <= base;
	end

	// A quotient beyond the step range saturates; the clamp then decides the coordinate.
	always_ff @(posedge clk) begin
		rem_s[0] <= RW'(nm_s1);
		ovf_s[0] <= RW'(nm_s1) >= (RW'(dm_s1) << QB);
		q_s[0] <= '0;
		dm_s[0] <= dm_s1;
		neg_s[0] <= neg_s1;
		dz_s[0] <= dz_s1;
		base_s[0] <= base_s1;
	end

	// One quotient bit per stage, most significant first.
	for (genvar i = 0; i < QB; i++) begin : g_step
		logic [RW-1:0] dsh;
		logic          ge;

		assign dsh = RW'(dm_s[i]) << (QB - 1 - i);
		assign ge = (rem_s[i] >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[i+1] <= ge ? (rem_s[i] - dsh) : rem_s[i];
			q_s[i+1] <= q_s[i] | (QB'(ge) << (QB - 1 - i));
			dm_s[i+1] <= dm_s[i];
			ovf_s[i+1] <= ovf_s[i];
			neg_s[i+1] <= neg_s[i];
			dz_s[i+1] <= dz_s[i];
			base_s[i+1] <= base_s[i];
		end
	end

	// Round to nearest with ties away from zero; a zero denominator gives zero.
	always_ff @(posedge clk) begin
		if (dz_s[QB]) begin
			qm_sr <= '0;
		end else if (ovf_s[QB]) begin
			qm_sr <= QW'(1) << QB;
		end else begin
			qm_sr <= QW'(q_s[QB]) + QW'((rem_s[QB] << 1) >= RW'(dm_s[QB]));
		end
		neg_sr <= neg_s[QB];
		base_sr <= base_s[QB];
	end

	// Apply the sign, add the base and clamp to the coordinate range.
	always_comb begin
		qs = neg_sr ? -$signed({1'b0, qm_sr}) : $signed({1'b0, qm_sr});
		sum = SW'(base_sr) + SW'(qs);
		fits = (sum[SW-1:CW-1] == '0) || (sum[SW-1:CW-1] == '1);
	end

	always_ff @(posedge clk) begin
		if (fits) begin
			coord <= sum[CW-1:0];
		end else if (sum[SW-1]) begin
			coord <= {1'b1, {(CW-1){1'b0}}};
		end else begin
			coord <= {1'b0, {(CW-1){1'b1}}};
		end
	end

endmodule

### hdl/closest_point_on_triangle.sv
`timescale 1ns / 1ps
// Closest point on a triangle to a query point, one transaction per clock cycle.
// Each accepted transaction gives one result, strobed on done.
// Throughput: one transaction per cycle; busy is never raised, and results cannot be held off.
// The depth is set by the split wide multipliers and the 36-step restoring divider.
// Reset clears the valid bits of every stage; data registers are not reset.
module closest_point_on_triangle
	import cpt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  crd_t point_x,
	input  crd_t point_y,
	input  crd_t point_z,
	input  crd_t vert_a_x,
	input  crd_t vert_a_y,
	input  crd_t vert_a_z,
	input  crd_t vert_b_x,
	input  crd_t vert_b_y,
	input  crd_t vert_b_z,
	input  crd_t vert_c_x,
	input  crd_t vert_c_y,
	input  crd_t vert_c_z,
	output logic done,
	output crd_t near_x,
	output crd_t near_y,
	output crd_t near_z,
	output logic [2:0] region
);

	// Operand pairs of the cross terms: vc, vb and va each take two products.
	localparam int MX [6] = '{0, 2, 4, 0, 2, 4};
	localparam int MY [6] = '{3, 1, 1, 5, 5, 3};

	crd_t p_in [3];
	crd_t a_in [3];
	crd_t b_in [3];
	crd_t c_in [3];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;

	geo_t g_s1, g_s2, g_s3, g_s4, g_s5, g_s6;
	dif_t ap_s1 [3];
	dif_t bp_s1 [3];
	dif_t cp_s1 [3];
	dif_t dl [6][3];
	dif_t dr [6][3];
	pro_t pr_s2 [6][3];
	dot_t d_s3 [6];

	logic signed [2*HW-1:0] hh_s4 [6];
	logic signed [2*HW:0]   hl_s4 [6];
	logic signed [2*HW:0]   lh_s4 [6];
	logic [2*HW-1:0]        ll_s4 [6];
	logic signed [DTW:0]    e43, e56;
	sel_t sel_d, sel_s4, sel_s5, sel_s6;

	logic signed [MDW-1:0] mid [6];
	logic signed [MW-1:0]  m_s5 [6];
	logic signed [VW-1:0]  wa_s6, wb_s6, wc_s6;

	par_t       den_int;
	region_t    rg_d;
	crd_t [2:0] base_d;
	dif_t [2:0] dir_d;
	par_t       t1_d, t2_d, den_d;

	region_t    rg_s7, rg_s8, rg_s9, rg_s10;
	crd_t [2:0] base_s7, base_s8, base_s9, base_s10;
	dif_t [2:0] d1_s7, d2_s7;
	par_t       t1_s7, t2_s7;
	par_t       den_s7, den_s8, den_s9, den_s10;

	logic [TXW-1:0] tx1, tx2;
	logic signed [PPW-1:0] pp_s8 [3][2][NCK];
	logic signed [PRW-1:0] prd_d [3][2];
	logic signed [PRW-1:0] prd_s9 [3][2];
	logic signed [NW-1:0]  num_s10 [3];

	crd_t    nr [3];
	logic    ov [3];
	region_t rg_q [DIV_LAT];

	assign busy = 1'b0;

	assign p_in[0] = point_x;
	assign p_in[1] = point_y;
	assign p_in[2] = point_z;
	assign a_in[0] = vert_a_x;
	assign a_in[1] = vert_a_y;
	assign a_in[2] = vert_a_z;
	assign b_in[0] = vert_b_x;
	assign b_in[1] = vert_b_y;
	assign b_in[2] = vert_b_z;
	assign c_in[0] = vert_c_x;
	assign c_in[1] = vert_c_y;
	assign c_in[2] = vert_c_z;

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
		end
	end

	// Stage 1: edge vectors and vectors from each vertex to the query point.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			g_s1.a[k] <= a_in[k];
			g_s1.b[k] <= b_in[k];
			g_s1.c[k] <= c_in[k];
			g_s1.ab[k] <= DW'(b_in[k]) - DW'(a_in[k]);
			g_s1.ac[k] <= DW'(c_in[k]) - DW'(a_in[k]);
			g_s1.bc[k] <= DW'(c_in[k]) - DW'(b_in[k]);
			ap_s1[k] <= DW'(p_in[k]) - DW'(a_in[k]);
			bp_s1[k] <= DW'(p_in[k]) - DW'(b_in[k]);
			cp_s1[k] <= DW'(p_in[k]) - DW'(c_in[k]);
		end
	end

	// Operands of the six dot products d1 to d6.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dl[0][k] = g_s1.ab[k];
			dr[0][k] = ap_s1[k];
			dl[1][k] = g_s1.ac[k];
			dr[1][k] = ap_s1[k];
			dl[2][k] = g_s1.ab[k];
			dr[2][k] = bp_s1[k];
			dl[3][k] = g_s1.ac[k];
			dr[3][k] = bp_s1[k];
			dl[4][k] = g_s1.ab[k];
			dr[4][k] = cp_s1[k];
			dl[5][k] = g_s1.ac[k];
			dr[5][k] = cp_s1[k];
		end
	end

	// Stage 2: per-axis products of the dot products.
	always_ff @(posedge clk) begin
		for (int j = 0; j < 6; j++) begin
			for (int k = 0; k < 3; k++) begin
				pr_s2[j][k] <= dl[j][k] * dr[j][k];
			end
		end
		g_s2 <= g_s1;
	end

	// Stage 3: dot product sums.
	always_ff @(posedge clk) begin
		for (int j = 0; j < 6; j++) begin
			d_s3[j] <= DTW'(pr_s2[j][0]) + DTW'(pr_s2[j][1]) + DTW'(pr_s2[j][2]);
		end
		g_s3 <= g_s2;
	end

	// Edge parameters and the region tests on the dot products alone.
	always_comb begin
		e43 = d_s3[3] - d_s3[2];
		e56 = d_s3[4] - d_s3[5];
		sel_d.t_ab = TW'(d_s3[0]);
		sel_d.t_ac = TW'(d_s3[1]);
		sel_d.t_bc = TW'(e43);
		sel_d.n_ab = TW'(d_s3[0]) - TW'(d_s3[2]);
		sel_d.n_ac = TW'(d_s3[1]) - TW'(d_s3[5]);
		sel_d.n_bc = TW'(e43) + TW'(e56);
		sel_d.f0 = (d_s3[0] <= 0) && (d_s3[1] <= 0);
		sel_d.f1 = (d_s3[2] >= 0) && (e43 <= 0);
		sel_d.f2p = (d_s3[0] >= 0) && (d_s3[2] <= 0);
		sel_d.f3 = (d_s3[5] >= 0) && (e56 <= 0);
		sel_d.f4p = (d_s3[1] >= 0) && (d_s3[5] <= 0);
		sel_d.f5p = (e43 >= 0) && (e56 >= 0);
	end

	// Stage 4: cross-term products split into half-width partial products.
	always_ff @(posedge clk) begin
		for (int m = 0; m < 6; m++) begin
			hh_s4[m] <= $signed(d_s3[MX[m]][DTW-1:HW]) * $signed(d_s3[MY[m]][DTW-1:HW]);
			hl_s4[m] <= $signed(d_s3[MX[m]][DTW-1:HW]) * $signed({1'b0, d_s3[MY[m]][HW-1:0]});
			lh_s4[m] <= $signed({1'b0, d_s3[MX[m]][HW-1:0]}) * $signed(d_s3[MY[m]][DTW-1:HW]);
			ll_s4[m] <= d_s3[MX[m]][HW-1:0] * d_s3[MY[m]][HW-1:0];
		end
		sel_s4 <= sel_d;
		g_s4 <= g_s3;
	end

	// Stage 5: assemble the full cross-term products.
	always_comb begin
		for (int m = 0; m < 6; m++) begin
			mid[m] = MDW'(hl_s4[m]) + MDW'(lh_s4[m]);
		end
	end

	always_ff @(posedge clk) begin
		for (int m = 0; m < 6; m++) begin
			m_s5[m] <= {hh_s4[m], {(2*HW){1'b0}}} + MW'($signed({mid[m], {HW{1'b0}}}))
				+ MW'(ll_s4[m]);
		end
		sel_s5 <= sel_s4;
		g_s5 <= g_s4;
	end

	// Stage 6: barycentric numerators va, vb and vc.
	always_ff @(posedge clk) begin
		wc_s6 <= VW'(m_s5[0]) - VW'(m_s5[1]);
		wb_s6 <= VW'(m_s5[2]) - VW'(m_s5[3]);
		wa_s6 <= VW'(m_s5[4]) - VW'(m_s5[5]);
		sel_s6 <= sel_s5;
		g_s6 <= g_s5;
	end

	// Region choice in priority order, and the operands of the closest point.
	always_comb begin
		den_int = TW'(wa_s6) + TW'(wb_s6) + TW'(wc_s6);
		rg_d = RG_INT;
		base_d = g_s6.a;
		dir_d = g_s6.ab;
		t1_d = '0;
		t2_d = '0;
		den_d = '0;
		if (sel_s6.f0) begin
			rg_d = RG_A;
		end else if (sel_s6.f1) begin
			rg_d = RG_B;
			base_d = g_s6.b;
		end else if ((wc_s6 <= 0) && sel_s6.f2p) begin
			rg_d = RG_AB;
			t1_d = sel_s6.t_ab;
			den_d = sel_s6.n_ab;
		end else if (sel_s6.f3) begin
			rg_d = RG_C;
			base_d = g_s6.c;
		end else if ((wb_s6 <= 0) && sel_s6.f4p) begin
			rg_d = RG_AC;
			dir_d = g_s6.ac;
			t1_d = sel_s6.t_ac;
			den_d = sel_s6.n_ac;
		end else if ((wa_s6 <= 0) && sel_s6.f5p) begin
			rg_d = RG_BC;
			base_d = g_s6.b;
			dir_d = g_s6.bc;
			t1_d = sel_s6.t_bc;
			den_d = sel_s6.n_bc;
		end else if (den_int == '0) begin
			rg_d = RG_DEG;
		end else begin
			rg_d = RG_INT;
			t1_d = TW'(wb_s6);
			t2_d = TW'(wc_s6);
			den_d = den_int;
		end
	end

	// Stage 7: selected operands.
	always_ff @(posedge clk) begin
		rg_s7 <= rg_d;
		base_s7 <= base_d;
		d1_s7 <= dir_d;
		d2_s7 <= g_s6.ac;
		t1_s7 <= t1_d;
		t2_s7 <= t2_d;
		den_s7 <= den_d;
	end

	// Stage 8: numerator partial products, one chunk of the parameter each.
	assign tx1 = TXW'(t1_s7);
	assign tx2 = TXW'(t2_s7);

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			for (int c = 0; c < NCK; c++) begin
				if (c == NCK - 1) begin
					pp_s8[k][0][c] <= d1_s7[k] * $signed(tx1[c*CKW +: CKW]);
					pp_s8[k][1][c] <= d2_s7[k] * $signed(tx2[c*CKW +: CKW]);
				end else begin
					pp_s8[k][0][c] <= d1_s7[k] * $signed({1'b0, tx1[c*CKW +: CKW]});
					pp_s8[k][1][c] <= d2_s7[k] * $signed({1'b0, tx2[c*CKW +: CKW]});
				end
			end
		end
		rg_s8 <= rg_s7;
		base_s8 <= base_s7;
		den_s8 <= den_s7;
	end

	// Stage 9: assemble both numerator products per axis.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int j = 0; j < 2; j++) begin
				prd_d[k][j] = '0;
				for (int c = 0; c < NCK; c++) begin
					prd_d[k][j] = prd_d[k][j] + (PRW'(pp_s8[k][j][c]) <<< (CKW * c));
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prd_s9 <= prd_d;
		rg_s9 <= rg_s8;
		base_s9 <= base_s8;
		den_s9 <= den_s8;
	end

	// Stage 10: numerator per axis.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			num_s10[k] <= NW'(prd_s9[k][0]) + NW'(prd_s9[k][1]);
		end
		rg_s10 <= rg_s9;
		base_s10 <= base_s9;
		den_s10 <= den_s9;
	end

	// One divider lane per axis.
	for (genvar k = 0; k < 3; k++) begin : g_lane
		cpt_div u_div (
			.clk     (clk),
			.arst_n  (arst_n),
			.in_vld  (v_s10),
			.num     (num_s10[k]),
			.den     (den_s10),
			.base    (base_s10[k]),
			.out_vld (ov[k]),
			.coord   (nr[k])
		);
	end

	// Region code follows the divider latency.
	always_ff @(posedge clk) begin
		rg_q[0] <= rg_s10;
		for (int i = 1; i < DIV_LAT; i++) begin
			rg_q[i] <= rg_q[i-1];
		end
	end

	assign done = ov[0] & ov[1] & ov[2];
	assign near_x = nr[0];
	assign near_y = nr[1];
	assign near_z = nr[2];
	assign region = rg_q[DIV_LAT-1];

`ifndef SYNTH
	// Every result comes from a transaction that the block accepted.
	a_done_origin: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a matching transaction");

	// Vertex A and degenerate results return vertex A unchanged.
	a_vertex_a: assert property (@(posedge clk) disable iff (!arst_n)
		done && (region == RG_A || region == RG_DEG) |->
		near_x == $past(vert_a_x, LAT) && near_y == $past(vert_a_y, LAT) &&
		near_z == $past(vert_a_z, LAT))
		else $error("vertex A region returned another point");

	// Vertex B results return vertex B unchanged.
	a_vertex_b: assert property (@(posedge clk) disable iff (!arst_n)
		done && (region == RG_B) |->
		near_x == $past(vert_b_x, LAT) && near_y == $past(vert_b_y, LAT) &&
		near_z == $past(vert_b_z, LAT))
		else $error("vertex B region returned another point");
`endif

endmodule
